[rtl/core/assert_macros.svh]
// Assertion macros used by the interval pair overlap set RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define IPOS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ipos assertion failed");

// Clocked assertion that must also hold during reset.
`define IPOS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ipos assertion failed");

`endif

[rtl/core/ipos_pkg.sv]
// Package with types, codes and defaults of the interval pair overlap set.
`timescale 1ns / 1ps

package ipos_pkg;

    // Field widths.
    localparam int POS_W = 64;
    localparam int CMD_W = 2;

    // Default list capacity.
    localparam int MAX_PAIRS_DEF = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // One input item.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
    } t_cmd_item;

    // One result item.
    typedef struct packed {
        logic inside_hit;
        logic endpoint_hit;
        logic list_empty;
        logic insert_dropped;
    } t_res;

    // Access strobes from the sequencer to the pair memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

[rtl/core/ipos_if.sv]
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps

interface ipos_cmd_if;
    import ipos_pkg::*;

    logic      valid;
    logic      ready;
    t_cmd_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipos_res_if;
    import ipos_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ipos_pair_mem.sv]
// Pair memory: one write port and one registered read port.
`timescale 1ns / 1ps

module ipos_pair_mem #(
    parameter int DEPTH = ipos_pkg::MAX_PAIRS_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  ipos_pkg::t_mem_ctl         i_ctl,
    input  logic [IDX_W-1:0]           i_wr_addr,
    input  logic [ipos_pkg::POS_W-1:0] i_wr_low,
    input  logic [ipos_pkg::POS_W-1:0] i_wr_high,
    input  logic [IDX_W-1:0]           i_rd_addr,
    output logic [ipos_pkg::POS_W-1:0] o_rd_low,
    output logic [ipos_pkg::POS_W-1:0] o_rd_high
);
    import ipos_pkg::*;

    // Each entry holds the high end above the low end.
    logic [2*POS_W-1:0] r_mem [DEPTH];
    logic [2*POS_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_high, i_wr_low};
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_low  = r_rd_data[POS_W-1:0];
    assign o_rd_high = r_rd_data[2*POS_W-1:POS_W];

endmodule

[rtl/core/ipos_ctrl.sv]
// Sequencer: pair count, memory scan for queries and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipos_ctrl #(
    parameter int MAX_PAIRS = ipos_pkg::MAX_PAIRS_DEF,
    parameter int IDX_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ipos_cmd_if.sink                   i_cmd,
    ipos_res_if.source                 o_res,
    output ipos_pkg::t_mem_ctl         o_mem_ctl,
    output logic [IDX_W-1:0]           o_wr_addr,
    output logic [ipos_pkg::POS_W-1:0] o_wr_low,
    output logic [ipos_pkg::POS_W-1:0] o_wr_high,
    output logic [IDX_W-1:0]           o_rd_addr,
    input  logic [ipos_pkg::POS_W-1:0] i_rd_low,
    input  logic [ipos_pkg::POS_W-1:0] i_rd_high
);
    import ipos_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_cmp_vld;
    logic [POS_W-1:0] r_pos;
    logic             r_inside;
    logic             r_endpoint;
    t_res             r_out;
    logic             r_out_vld;

    logic             in_fire;
    logic             out_free;
    logic             out_load;
    logic             is_full;
    logic             rd_issue;
    logic             cmp_inside;
    logic             cmp_end;
    logic             acc_inside;
    logic             acc_end;
    logic             scan_last;
    logic             a_lt_b;

    // Handshake. A new item is taken only when idle and the result slot can be filled.
    assign out_free    = !r_out_vld || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    assign is_full = (r_count == CNT_W'(MAX_PAIRS));

    // Insert writes the ordered pair at the next free entry unless the list is full. A scan
    // only starts after the write edge, so no read can see a stale entry.
    assign a_lt_b          = i_cmd.data.pos_a < i_cmd.data.pos_b;
    assign o_mem_ctl.wr_en = in_fire && (i_cmd.data.command == CMD_INSERT) && !is_full;
    assign o_wr_addr       = r_count[IDX_W-1:0];
    assign o_wr_low        = a_lt_b ? i_cmd.data.pos_a : i_cmd.data.pos_b;
    assign o_wr_high       = a_lt_b ? i_cmd.data.pos_b : i_cmd.data.pos_a;

    // Scan reads one stored pair per cycle and compares it in the cycle after its read.
    assign rd_issue        = (r_state == S_SCAN) && (r_rd_idx != r_count);
    assign o_mem_ctl.rd_en = rd_issue;
    assign o_rd_addr       = r_rd_idx[IDX_W-1:0];

    assign cmp_inside = r_cmp_vld && (i_rd_low < r_pos) && (r_pos < i_rd_high);
    assign cmp_end    = r_cmp_vld && ((i_rd_low == r_pos) || (i_rd_high == r_pos));
    assign acc_inside = r_inside | cmp_inside;
    assign acc_end    = r_endpoint | cmp_end;
    assign scan_last  = (r_state == S_SCAN) && !rd_issue && r_cmp_vld;

    // The result register is loaded by every command except a query that starts a scan,
    // and by the end of a scan.
    assign out_load = (in_fire && !((i_cmd.data.command == CMD_QUERY) && (r_count != '0)))
                   || (scan_last && out_free)
                   || ((r_state == S_DONE) && out_free);

    // State, pair count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= rd_issue;
            if (rd_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_cmp_vld) begin
                r_inside   <= acc_inside;
                r_endpoint <= acc_end;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_cmd.data.command)
                            CMD_INSERT: begin
                                if (!is_full) begin
                                    r_count <= r_count + 1'b1;
                                end
                                r_out     <= '{inside_hit: 1'b0, endpoint_hit: 1'b0,
                                               list_empty: 1'b0, insert_dropped: is_full};
                            end
                            CMD_CLEAR: begin
                                r_count   <= '0;
                                r_out     <= '{inside_hit: 1'b0, endpoint_hit: 1'b0,
                                               list_empty: 1'b1, insert_dropped: 1'b0};
                            end
                            CMD_QUERY: begin
                                if (r_count == '0) begin
                                    r_out     <= '{inside_hit: 1'b0, endpoint_hit: 1'b0,
                                                   list_empty: 1'b1, insert_dropped: 1'b0};
                                end else begin
                                    r_pos      <= i_cmd.data.pos_a;
                                    r_rd_idx   <= '0;
                                    r_inside   <= 1'b0;
                                    r_endpoint <= 1'b0;
                                    r_state    <= S_SCAN;
                                end
                            end
                            default: begin
                                r_out     <= '{inside_hit: 1'b0, endpoint_hit: 1'b0,
                                               list_empty: (r_count == '0),
                                               insert_dropped: 1'b0};
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_last) begin
                        if (out_free) begin
                            r_out     <= '{inside_hit: acc_inside, endpoint_hit: acc_end,
                                           list_empty: 1'b0, insert_dropped: 1'b0};
                            r_state   <= S_IDLE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out     <= '{inside_hit: r_inside, endpoint_hit: r_endpoint,
                                       list_empty: 1'b0, insert_dropped: 1'b0};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The count never passes the capacity.
    `IPOS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_PAIRS))
    // An insert into a full list leaves the count unchanged.
    `IPOS_ASSERT(a_full_drop, i_clk, i_rst_n,
        (in_fire && (i_cmd.data.command == CMD_INSERT) && is_full) |=>
        (r_count == $past(r_count)))
    // Reads are issued only during a scan and only below the count.
    `IPOS_ASSERT(a_rd_range, i_clk, i_rst_n,
        o_mem_ctl.rd_en |-> ((r_state == S_SCAN) && (r_rd_idx < r_count)))
    // A result loaded at transfer reports the updated list state.
    `IPOS_ASSERT(a_empty_flag, i_clk, i_rst_n,
        (in_fire && (i_cmd.data.command != CMD_QUERY)) |=>
        (r_out_vld && (r_out.list_empty == (r_count == '0))))

endmodule

[rtl/core/interval_pair_overlap_set_unit.sv]
// Top level of the interval pair overlap set.
`timescale 1ns / 1ps

// Keeps up to MAX_PAIRS pairs, each stored low end first, in one on-chip
// memory. Insert, clear and unused command codes load their result at the
// transfer. A query over N stored pairs reads the memory once per pair
// through its single read port and loads its result when the scan ends and
// the result register is free; a query of an empty list loads its result
// at the transfer. One item is in work at a time: the next command is taken
// once the block is idle and the result register is free or being drained.
// An insert into a full list changes nothing and sets insert_dropped.
module interval_pair_overlap_set_unit #(
    parameter int MAX_PAIRS = ipos_pkg::MAX_PAIRS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipos_cmd_if.sink    i_cmd,
    ipos_res_if.source  o_res
);
    import ipos_pkg::*;

    localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    t_mem_ctl         mem_ctl;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [POS_W-1:0] wr_low;
    logic [POS_W-1:0] wr_high;
    logic [POS_W-1:0] rd_low;
    logic [POS_W-1:0] rd_high;

    // Sequencer with count and result register.
    ipos_ctrl #(
        .MAX_PAIRS (MAX_PAIRS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_res     (o_res),
        .o_mem_ctl (mem_ctl),
        .o_wr_addr (wr_addr),
        .o_wr_low  (wr_low),
        .o_wr_high (wr_high),
        .o_rd_addr (rd_addr),
        .i_rd_low  (rd_low),
        .i_rd_high (rd_high)
    );

    // Stored pairs.
    ipos_pair_mem #(
        .DEPTH (MAX_PAIRS),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_low  (wr_low),
        .i_wr_high (wr_high),
        .i_rd_addr (rd_addr),
        .o_rd_low  (rd_low),
        .o_rd_high (rd_high)
    );

endmodule

[bench/interval_pair_overlap_set_checker.sv]
// Checker that predicts and compares the results of the interval pair overlap set.
`timescale 1ns / 1ps

module interval_pair_overlap_set_checker #(
    parameter int MAX_PAIRS = ipos_pkg::MAX_PAIRS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ipos_cmd_if  i_cmd,
    ipos_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending_count
);
    import ipos_pkg::*;

    // Shadow copy of the stored pairs, low end first.
    logic [POS_W-1:0] shadow_low  [MAX_PAIRS];
    logic [POS_W-1:0] shadow_high [MAX_PAIRS];
    int unsigned      shadow_count;

    // Outcomes predicted for accepted commands, oldest first.
    t_res             pending_outcomes [$];
    int               mismatch_total;
    t_res             oldest;

    // Applies one command to the shadow list and returns the outcome it must give.
    function automatic t_res predict_outcome(input t_cmd_item item);
        t_res outcome;
        int   idx;
        outcome = '0;
        case (item.command)
            CMD_INSERT: begin
                if (shadow_count >= MAX_PAIRS) begin
                    outcome.insert_dropped = 1'b1;
                end else begin
                    if (item.pos_a < item.pos_b) begin
                        shadow_low[shadow_count]  = item.pos_a;
                        shadow_high[shadow_count] = item.pos_b;
                    end else begin
                        shadow_low[shadow_count]  = item.pos_b;
                        shadow_high[shadow_count] = item.pos_a;
                    end
                    shadow_count++;
                end
            end
            CMD_CLEAR: begin
                shadow_count = 0;
            end
            CMD_QUERY: begin
                for (idx = 0; idx < shadow_count; idx++) begin
                    if (shadow_low[idx] < item.pos_a && item.pos_a < shadow_high[idx])
                        outcome.inside_hit = 1'b1;
                    if (shadow_low[idx] == item.pos_a || shadow_high[idx] == item.pos_a)
                        outcome.endpoint_hit = 1'b1;
                end
            end
            default: begin
                // The unused code leaves the list alone.
            end
        endcase
        outcome.list_empty = (shadow_count == 0);
        return outcome;
    endfunction

    // Reports one result field that differs from its prediction.
    task automatic compare_flag(input string field, input logic want, input logic got);
        if (got !== want) begin
            $error("%s mismatch: expected %0b, actual %0b", field, want, got);
            mismatch_total++;
        end
    endtask

    // Result transfers are checked before command transfers of the same edge are
    // predicted, since a result always belongs to an earlier command.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_outcomes.delete();
            shadow_count = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatch_total++;
                end else begin
                    oldest = pending_outcomes.pop_front();
                    compare_flag("inside_hit", oldest.inside_hit, i_res.data.inside_hit);
                    compare_flag("endpoint_hit", oldest.endpoint_hit, i_res.data.endpoint_hit);
                    compare_flag("list_empty", oldest.list_empty, i_res.data.list_empty);
                    compare_flag("insert_dropped", oldest.insert_dropped,
                                 i_res.data.insert_dropped);
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                pending_outcomes.insert(pending_outcomes.size(), predict_outcome(i_cmd.data));
            end
        end
        o_fail_count    <= mismatch_total;
        o_pending_count <= pending_outcomes.size();
    end

endmodule

[bench/interval_pair_overlap_set_unit_test.sv]
// Testbench top that drives the interval pair overlap set and gives the verdict.
`timescale 1ns / 1ps

module interval_pair_overlap_set_unit_test;
    import ipos_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [POS_W-1:0] POS_MAX    = '1;
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int TARGET_ITEMS = 1450;
    localparam int QUIET_TAIL   = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ipos_cmd_if cmd_if ();
    ipos_res_if res_if ();

    int          fail_count;
    int          pending_count;
    bit          idling_enabled = 1'b0;
    int unsigned items_counted  = 0;

    // Positions inserted since the last clear, used to aim queries at stored pairs.
    logic [POS_W-1:0] position_pool [$];

    interval_pair_overlap_set_unit #(
        .MAX_PAIRS (MAX_PAIRS_DEF)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    interval_pair_overlap_set_checker #(
        .MAX_PAIRS (MAX_PAIRS_DEF)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_if),
        .i_res           (res_if),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Clock generation.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Small values half the time so pairs overlap, with extremes and full-width values mixed in.
    function automatic logic [POS_W-1:0] random_position();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return POS_W'($urandom_range(0, 1000));
            4:          return POS_W'($urandom_range(0, 15));
            5:          return POS_MAX - POS_W'($urandom_range(0, 15));
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    // Query positions land on or next to stored ends most of the time.
    function automatic logic [POS_W-1:0] query_position();
        logic [POS_W-1:0] anchor;
        if (position_pool.size() != 0 && $urandom_range(0, 9) < 6) begin
            anchor = position_pool[$urandom_range(0, position_pool.size() - 1)];
            case ($urandom_range(0, 2))
                0:       return anchor - 1'b1;
                1:       return anchor + 1'b1;
                default: return anchor;
            endcase
        end
        return random_position();
    endfunction

    // Offers one command after an optional gap and waits for its transfer.
    // Entered and left just after a falling edge.
    task automatic send_command(input logic [CMD_W-1:0] command,
                                input logic [POS_W-1:0] pos_a,
                                input logic [POS_W-1:0] pos_b);
        int unsigned gap;
        gap = 0;
        if (idling_enabled && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 15);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= {command, pos_a, pos_b};
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
        if (command == CMD_INSERT) begin
            position_pool.insert(position_pool.size(), pos_a);
            position_pool.insert(position_pool.size(), pos_b);
        end else if (command == CMD_CLEAR) begin
            position_pool.delete();
        end
        if (command != CMD_UNUSED)
            items_counted++;
    endtask

    // Result side: ready with random stall bursts while idling is enabled.
    initial begin : result_drain
        int unsigned stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idling_enabled && stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (idling_enabled && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    // Ends the run when no transfer happens for too long.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** interval_pair_overlap_set_unit: FAILED **");
        $finish;
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int unsigned pair_goal;
        int unsigned query_goal;
        int unsigned n;
        logic [POS_W-1:0] first_pos;

        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty list, swapped and equal ends, extremes, full list.
        idling_enabled = 1'b1;
        send_command(CMD_QUERY, '0, POS_MAX);
        send_command(CMD_CLEAR, POS_MAX, POS_MAX);
        send_command(CMD_INSERT, 64'd5, 64'd100);
        send_command(CMD_INSERT, 64'd200, 64'd150);
        send_command(CMD_INSERT, 64'd300, 64'd300);
        send_command(CMD_QUERY, 64'd50, '0);
        send_command(CMD_QUERY, 64'd100, '0);
        send_command(CMD_QUERY, 64'd300, '0);
        send_command(CMD_INSERT, '0, POS_MAX);
        send_command(CMD_QUERY, '0, '0);
        send_command(CMD_UNUSED, POS_MAX, POS_MAX);
        for (n = 0; n < MAX_PAIRS_DEF - 4; n++)
            send_command(CMD_INSERT, 64'd1000 + 10 * n, 64'd1005 + 10 * n);
        send_command(CMD_INSERT, 64'd7, 64'd9);
        send_command(CMD_QUERY, POS_MAX, '0);
        send_command(CMD_CLEAR, '0, '0);
        send_command(CMD_QUERY, 64'd50, '0);

        // Random part: sessions of an optional clear, a run of inserts and aimed queries.
        while (items_counted < TARGET_ITEMS) begin
            idling_enabled = (items_counted + QUIET_TAIL < TARGET_ITEMS)
                             && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                send_command(CMD_CLEAR, random_position(), random_position());
            case ($urandom_range(0, 9))
                0:       pair_goal = $urandom_range(14, 19);
                1:       pair_goal = 0;
                default: pair_goal = $urandom_range(1, 6);
            endcase
            for (n = 0; n < pair_goal; n++) begin
                first_pos = random_position();
                if ($urandom_range(0, 7) == 0)
                    send_command(CMD_INSERT, first_pos, first_pos);
                else
                    send_command(CMD_INSERT, first_pos, random_position());
            end
            query_goal = $urandom_range(2, 12);
            for (n = 0; n < query_goal; n++) begin
                case ($urandom_range(0, 19))
                    0:       send_command(CMD_UNUSED, random_position(), random_position());
                    1:       send_command(CMD_INSERT, random_position(), random_position());
                    default: send_command(CMD_QUERY, query_position(), random_position());
                endcase
            end
        end
        cmd_if.valid <= 1'b0;

        // Drain outstanding results, then allow for the block's latency.
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** interval_pair_overlap_set_unit: PASSED **");
        else
            $display("** interval_pair_overlap_set_unit: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ipos_pkg.sv
rtl/core/ipos_if.sv
rtl/core/ipos_pair_mem.sv
rtl/core/ipos_ctrl.sv
rtl/core/interval_pair_overlap_set_unit.sv
bench/interval_pair_overlap_set_checker.sv
bench/interval_pair_overlap_set_unit_test.sv
